// ----- design/fvv_pkg.sv -----
// Shared types and constants for the viewport fitting block.
package fvv_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int VIEW_W     = 13;
    localparam int RATIO_W    = 18;
    localparam int COORD_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RATIO  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PREP,
        ST_DIV,
        ST_READ,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SUM
    } t_state;

    typedef enum logic [0:0] {
        OUT_IDLE,
        OUT_SHOW
    } t_out;

endpackage

// ----- design/fit_vertices_to_viewport.sv -----
// Top level: loads vertices, fits their bounding box to the viewport, streams them out.
// After the last vertex the block runs a set-up step and then the bit-serial scale divider;
// each stored vertex then takes one memory read and four steps per axis through one shared
// 33 x 32 multiplier, and its memory read waits until the previous result beat has left.
// Throughput: one vertex per cycle while loading; no vertex is taken during readout.
// Reset (synchronous, active low) empties the box, count and drop flag and restores the
// viewport registers; the vertex memory is not cleared, since only written entries are used.
module fit_vertices_to_viewport #(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Vertex input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_x,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_y,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_z,
    input  logic                             i_last_vertex,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic signed [fvv_pkg::COORD_W-1:0] o_out_x,
    output logic signed [fvv_pkg::COORD_W-1:0] o_out_y,
    output logic signed [fvv_pkg::COORD_W-1:0] o_out_z,
    output logic                             o_degenerate,
    output logic                             o_overflowed,
    output logic                             o_last_out,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fvv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fvv_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import fvv_pkg::*;

    // Address and count widths follow the capacity.
    localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW   = $clog2(MAX_VERTICES + 1);
    localparam int KW   = VIEW_W + RATIO_W;          // min(width,height) * ratio
    localparam int DW   = KW + FRAC_BITS + 16;       // dividend bits for the scale
    localparam int ITW  = $clog2(DW + 1);
    localparam int SW   = 64;                        // scale, 32 fraction bits
    localparam int AMW  = COORD_W + 1;               // magnitude of an offset
    localparam int PW   = AMW + 32;                  // one partial product
    localparam int CAPB = 40;                        // scaled offsets are capped at 2^40
    localparam int RW   = CAPB + 1;
    localparam int TW   = RW + 3;                    // signed sum before saturation
    localparam int MW   = 3 * COORD_W;

    localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] NEG_MAX = {1'b1, {(COORD_W-1){1'b0}}};

    t_state r_state, n_state;

    // Configuration registers.
    logic [VIEW_W-1:0]  r_view_w, r_view_h;
    logic [RATIO_W-1:0] r_ratio;

    // Load state: box, count and drop flag.
    logic signed [COORD_W-1:0] r_min [3];
    logic signed [COORD_W-1:0] r_max [3];
    logic [CW-1:0]             r_count;
    logic                      r_drop;

    // Fit results.
    logic signed [COORD_W-1:0] r_ctr [3];
    logic [COORD_W-1:0]        r_ext;
    logic                      r_degen;
    logic [KW-1:0]             r_k;

    // Divider.
    logic [DW-1:0]   r_dvd;
    logic [COORD_W:0] r_rem;
    logic [SW-1:0]   r_quo;
    logic            r_qsat;
    logic [ITW-1:0]  r_iter;
    logic [SW-1:0]   r_scale;

    // Readout.
    logic [CW-1:0]   r_idx;
    logic [1:0]      r_axis;
    logic [AMW-1:0]  r_mag;
    logic            r_neg;
    logic [PW-1:0]   r_prod_lo, r_prod_hi;
    logic            r_out_show;

    // Vertex memory, one word of x, y and z per entry.
    logic [MW-1:0] r_mem [MAX_VERTICES];
    logic [MW-1:0] r_rd_data;

    logic in_acc, out_acc, store_ok, mem_rd_en;

    // A vertex is only taken while loading; a result waits in the output registers.
    always_comb begin
        o_in_stall  = 1'b1;
        mem_rd_en   = 1'b0;
        unique case (r_state)
            ST_LOAD: o_in_stall = 1'b0;
            ST_READ: mem_rd_en  = !r_out_show;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_show;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_show && !i_out_stall;
    assign store_ok    = r_count < CW'(MAX_VERTICES);

    // Next state. Readout waits in the read state until the previous result beat has gone;
    // once every vertex is out, loading resumes as the final beat is taken.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD:   if (in_acc && i_last_vertex) n_state = ST_PREP;
            ST_PREP:   n_state = ST_DIV;
            ST_DIV:    if (r_iter == ITW'(DW)) n_state = ST_READ;
            ST_READ: begin
                if (r_idx == r_count) begin
                    if (!r_out_show || out_acc) n_state = ST_LOAD;
                end else if (mem_rd_en) begin
                    n_state = ST_ABS;
                end
            end
            ST_ABS:    n_state = ST_MUL_LO;
            ST_MUL_LO: n_state = ST_MUL_HI;
            ST_MUL_HI: n_state = ST_SUM;
            ST_SUM:    n_state = (r_axis == AXIS_Z) ? ST_READ : ST_ABS;
            default:   n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    // Configuration writes; an index past the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w <= VIEW_W'(640);
            r_view_h <= VIEW_W'(480);
            r_ratio  <= RATIO_W'(52429);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_VIEW_WIDTH:  r_view_w <= i_cfg_data[VIEW_W-1:0];
                CFG_VIEW_HEIGHT: r_view_h <= i_cfg_data[VIEW_W-1:0];
                CFG_FILL_RATIO:  r_ratio  <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Vertex memory: written while loading, read during readout.
    always_ff @(posedge i_clk) begin
        if (in_acc && store_ok)
            r_mem[r_count[AW-1:0]] <= {i_vert_z, i_vert_y, i_vert_x};
        if (mem_rd_en)
            r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // Bounding box, count and drop flag. They clear once the final result beat is taken.
    logic signed [COORD_W-1:0] in_v [3];
    assign in_v[0] = i_vert_x;
    assign in_v[1] = i_vert_y;
    assign in_v[2] = i_vert_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (out_acc && o_last_out)) begin
            for (int j = 0; j < 3; j++) begin
                r_min[j] <= POS_MAX;
                r_max[j] <= NEG_MAX;
            end
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (in_acc) begin
            if (store_ok) begin
                for (int j = 0; j < 3; j++) begin
                    if (in_v[j] < r_min[j]) r_min[j] <= in_v[j];
                    if (in_v[j] > r_max[j]) r_max[j] <= in_v[j];
                end
                r_count <= r_count + CW'(1);
            end else begin
                r_drop <= 1'b1;
            end
        end
    end

    // Set-up: extents, centres and the scale numerator.
    logic [COORD_W:0]        ex, ey;
    logic signed [COORD_W:0] ctr_sum [3];
    logic [VIEW_W-1:0]       view_min;

    always_comb begin
        ex = 33'(signed'(r_max[0]) - signed'(r_min[0]));
        ey = 33'(signed'(r_max[1]) - signed'(r_min[1]));
        for (int j = 0; j < 3; j++)
            ctr_sum[j] = 33'(r_min[j]) + 33'(r_max[j]);
        view_min = (r_view_w < r_view_h) ? r_view_w : r_view_h;
    end

    // Restoring division, one quotient bit a cycle; a quotient at or above 2^64 saturates.
    logic [COORD_W+1:0] rem_try;
    logic [COORD_W:0]   rem_sh;
    assign rem_sh  = {r_rem[COORD_W-1:0], r_dvd[DW-1]};
    assign rem_try = {1'b0, rem_sh} - {2'b00, r_ext};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else begin
            unique case (r_state)
                ST_PREP: begin
                    for (int j = 0; j < 3; j++)
                        r_ctr[j] <= ctr_sum[j][COORD_W:1];
                    r_ext   <= (ex > ey) ? ex[COORD_W-1:0] : ey[COORD_W-1:0];
                    r_degen <= (ex == '0) && (ey == '0);
                    r_k     <= KW'(view_min * r_ratio);
                    r_iter  <= '0;
                    r_rem   <= '0;
                    r_quo   <= '0;
                    r_qsat  <= 1'b0;
                end
                ST_DIV: begin
                    if (r_iter == '0) begin
                        r_dvd  <= {r_k, (FRAC_BITS + 16)'(0)};
                        r_iter <= r_iter + ITW'(1);
                    end else if (r_iter != ITW'(DW)) begin
                        r_dvd  <= {r_dvd[DW-2:0], 1'b0};
                        r_qsat <= r_qsat | r_quo[SW-1];
                        if (!rem_try[COORD_W+1]) begin
                            r_rem <= rem_try[COORD_W:0];
                            r_quo <= {r_quo[SW-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_quo <= {r_quo[SW-2:0], 1'b0};
                        end
                        r_iter <= r_iter + ITW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // The divider above spends its first step loading the dividend, so DW - 1 bits are
    // resolved there; the final bit is taken on the way into readout.
    logic [SW-1:0] quo_last;
    logic          sat_last;
    assign quo_last = {r_quo[SW-2:0], !rem_try[COORD_W+1]};
    assign sat_last = r_qsat | r_quo[SW-1];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_iter == ITW'(DW)) begin
            if (r_degen)       r_scale <= '0;
            else if (sat_last) r_scale <= '1;
            else               r_scale <= quo_last;
        end
    end

    // Readout datapath: offset magnitude, two partial products, cap, add half, saturate.
    logic signed [COORD_W-1:0] v_sel, c_sel;
    logic signed [COORD_W:0]   diff;
    logic [31:0]               mul_b;
    logic [PW-1:0]             mul_p;
    logic [PW:0]               r_full;
    logic [RW-1:0]             r_cap;
    logic signed [TW-1:0]      half, total;
    logic signed [COORD_W-1:0] res;

    always_comb begin
        case (r_axis)
            AXIS_X:  v_sel = r_rd_data[COORD_W-1:0];
            AXIS_Y:  v_sel = r_rd_data[2*COORD_W-1:COORD_W];
            default: v_sel = r_rd_data[MW-1:2*COORD_W];
        endcase
        case (r_axis)
            AXIS_X:  c_sel = r_ctr[0];
            AXIS_Y:  c_sel = r_ctr[1];
            default: c_sel = r_ctr[2];
        endcase
        diff  = 33'(v_sel) - 33'(c_sel);
        mul_b = (r_state == ST_MUL_LO) ? r_scale[31:0] : r_scale[SW-1:32];
        mul_p = PW'(r_mag) * PW'(mul_b);

        r_full = {1'b0, r_prod_hi} + (PW + 1)'(r_prod_lo[PW-1:32]);
        r_cap  = (r_full > (PW + 1)'(64'd1 << CAPB)) ? RW'(64'd1 << CAPB) : r_full[RW-1:0];

        case (r_axis)
            AXIS_X:  half = TW'({r_view_w[VIEW_W-1:1], FRAC_BITS'(0)});
            AXIS_Y:  half = TW'({r_view_h[VIEW_W-1:1], FRAC_BITS'(0)});
            default: half = '0;
        endcase
        total = r_neg ? half - TW'(r_cap) : half + TW'(r_cap);
        if (total > TW'(POS_MAX))      res = POS_MAX;
        else if (total < TW'(NEG_MAX)) res = NEG_MAX;
        else                           res = total[COORD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_show <= 1'b0;
            r_idx      <= '0;
            r_axis     <= AXIS_X;
        end else begin
            if (out_acc) r_out_show <= 1'b0;
            unique case (r_state)
                ST_PREP: r_idx <= '0;
                ST_READ: r_axis <= AXIS_X;
                ST_ABS: begin
                    r_neg <= diff[COORD_W];
                    r_mag <= diff[COORD_W] ? AMW'(-diff) : AMW'(diff);
                end
                ST_MUL_LO: r_prod_lo <= mul_p;
                ST_MUL_HI: r_prod_hi <= mul_p;
                ST_SUM: begin
                    case (r_axis)
                        AXIS_X:  o_out_x <= res;
                        AXIS_Y:  o_out_y <= res;
                        default: o_out_z <= res;
                    endcase
                    if (r_axis == AXIS_Z) begin
                        r_out_show   <= 1'b1;
                        o_degenerate <= r_degen;
                        o_overflowed <= r_drop;
                        o_last_out   <= (r_idx + CW'(1)) == r_count;
                        r_idx        <= r_idx + CW'(1);
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Checks on the sequencing.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_no_load_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("vertex accepted while a result is pending");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_out) |=> (r_count == '0 && !r_drop))
        else $error("load state not cleared after the run");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_idx <= r_count && r_idx != '0))
        else $error("readout index out of range");

endmodule

// ----- tb/fvv_checker.sv -----
// Checker for the viewport fitting block: predicts each result beat and compares it.
`timescale 1ns / 100ps
module fvv_checker #(
    parameter int MAX_VERTICES = 64,
    parameter int FRAC_BITS    = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_x,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_y,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_vert_z,
    input  logic                             i_last_vertex,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_out_x,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_out_y,
    input  logic signed [fvv_pkg::COORD_W-1:0] i_out_z,
    input  logic                             i_degenerate,
    input  logic                             i_overflowed,
    input  logic                             i_last_out,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [fvv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fvv_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import fvv_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               degen;
        logic               dropped;
        logic               last;
    } t_screen_vertex;

    localparam longint SCALED_CAP = 64'sd1 << 40;

    t_screen_vertex   screen_q[$];
    logic [12:0]      width_reg, height_reg;
    logic [17:0]      ratio_reg;
    longint           mem_x[MAX_VERTICES], mem_y[MAX_VERTICES], mem_z[MAX_VERTICES];
    longint           lo_box[3], hi_box[3];
    int               loaded;
    bit               dropped;

    assign o_pending = screen_q.size();

    function automatic longint sat_coord(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Offset times the unsigned 32.32 scale, truncated toward zero and capped.
    function automatic longint scale_offset(longint d, bit [63:0] s);
        bit [63:0] a, hi, lo, r;
        a  = (d < 0) ? 64'(-d) : 64'(d);
        hi = s >> 32;
        lo = s & 64'hFFFF_FFFF;
        if (hi != 0 && a > 64'(SCALED_CAP) / hi) begin
            r = 64'(SCALED_CAP);
        end else begin
            r = a * hi + ((a * lo) >> 32);
            if (r > 64'(SCALED_CAP)) r = 64'(SCALED_CAP);
        end
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    task automatic clear_box();
        for (int j = 0; j < 3; j++) begin
            lo_box[j] = 64'sd2147483647;
            hi_box[j] = -64'sd2147483648;
        end
        loaded  = 0;
        dropped = 0;
    endtask

    task automatic fit_model();
        longint         ex, ey, ext, ctr[3], half_w, half_h;
        bit [63:0]      m, num, q1, r1, s;
        bit             degen;
        t_screen_vertex e;
        ex    = hi_box[0] - lo_box[0];
        ey    = hi_box[1] - lo_box[1];
        ext   = (ex > ey) ? ex : ey;
        degen = (ext <= 0);
        for (int j = 0; j < 3; j++) ctr[j] = (lo_box[j] + hi_box[j]) >>> 1;
        m = (width_reg < height_reg) ? 64'(width_reg) : 64'(height_reg);
        s = 0;
        if (!degen) begin
            num = (m * 64'(ratio_reg)) << FRAC_BITS;
            q1  = num / 64'(ext);
            r1  = num % 64'(ext);
            if ((q1 >> 48) != 0) s = '1;
            else s = (q1 << 16) + ((r1 << 16) / 64'(ext));
        end
        half_w = longint'(64'(width_reg / 2) << FRAC_BITS);
        half_h = longint'(64'(height_reg / 2) << FRAC_BITS);
        for (int i = 0; i < loaded; i++) begin
            if (degen) begin
                e.x = 32'(sat_coord(half_w));
                e.y = 32'(sat_coord(half_h));
                e.z = '0;
            end else begin
                e.x = 32'(sat_coord(scale_offset(mem_x[i] - ctr[0], s) + half_w));
                e.y = 32'(sat_coord(scale_offset(mem_y[i] - ctr[1], s) + half_h));
                e.z = 32'(sat_coord(scale_offset(mem_z[i] - ctr[2], s)));
            end
            e.degen   = degen;
            e.dropped = dropped;
            e.last    = (i == loaded - 1);
            screen_q.push_back(e);
        end
        clear_box();
    endtask

    task automatic take_vertex();
        longint v[3];
        v[0] = i_vert_x;
        v[1] = i_vert_y;
        v[2] = i_vert_z;
        if (loaded < MAX_VERTICES) begin
            mem_x[loaded] = v[0];
            mem_y[loaded] = v[1];
            mem_z[loaded] = v[2];
            for (int j = 0; j < 3; j++) begin
                if (v[j] < lo_box[j]) lo_box[j] = v[j];
                if (v[j] > hi_box[j]) hi_box[j] = v[j];
            end
            loaded++;
        end else begin
            dropped = 1;
        end
        if (i_last_vertex) fit_model();
    endtask

    task automatic check_beat();
        t_screen_vertex e;
        if (screen_q.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("unexpected result beat x=%0d y=%0d z=%0d", i_out_x, i_out_y, i_out_z);
            return;
        end
        e = screen_q.pop_front();
        if (e.x !== i_out_x || e.y !== i_out_y || e.z !== i_out_z || e.degen !== i_degenerate
                || e.dropped !== i_overflowed || e.last !== i_last_out) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("result mismatch: expected x=%0d y=%0d z=%0d dg=%b ov=%b last=%b, got x=%0d y=%0d z=%0d dg=%b ov=%b last=%b",
                         e.x, e.y, e.z, e.degen, e.dropped, e.last,
                         i_out_x, i_out_y, i_out_z, i_degenerate, i_overflowed, i_last_out);
        end
    endtask

    initial begin
        o_fail_count = 0;
        width_reg    = 13'd640;
        height_reg   = 13'd480;
        ratio_reg    = 18'd52429;
        clear_box();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            ratio_reg  <= 18'd52429;
            clear_box();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VIEW_WIDTH:  width_reg  = i_cfg_data[12:0];
                    CFG_VIEW_HEIGHT: height_reg = i_cfg_data[12:0];
                    CFG_FILL_RATIO:  ratio_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) check_beat();
            if (i_in_valid && !i_in_stall) take_vertex();
        end
    end
endmodule

// ----- tb/tb.sv -----
// Testbench top: drives vertex models and register settings, then gives the verdict.
`timescale 1ns / 100ps
module tb;
    import fvv_pkg::*;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic signed [31:0] vert_x = 0, vert_y = 0, vert_z = 0;
    logic               last_vertex = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic signed [31:0] out_x, out_y, out_z;
    logic               degenerate, overflowed, last_out;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_VIEW_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = 0;
    int                 fail_count, pending;

    // Sender burst state: beats left in the current burst.
    int                 burst_left = 0;

    always #2 i_clk = ~i_clk;

    fit_vertices_to_viewport dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_vert_x(vert_x), .i_vert_y(vert_y), .i_vert_z(vert_z),
        .i_last_vertex(last_vertex),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_out_x(out_x), .o_out_y(out_y), .o_out_z(out_z),
        .o_degenerate(degenerate), .o_overflowed(overflowed), .o_last_out(last_out),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    fvv_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_vert_x(vert_x), .i_vert_y(vert_y), .i_vert_z(vert_z),
        .i_last_vertex(last_vertex),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_out_x(out_x), .i_out_y(out_y), .i_out_z(out_z),
        .i_degenerate(degenerate), .i_overflowed(overflowed), .i_last_out(last_out),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver changes its behaviour every so often: free running, random
    // stalls, or long mostly stalled stretches, so that stalls land on every readout step.
    int stall_mode = 0, stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Sends one vertex beat. Between bursts the valid may drop for a random gap;
    // within a burst it stays high from one beat to the next.
    task automatic send_vertex(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        vert_x      <= x;
        vert_y      <= y;
        vert_z      <= z;
        last_vertex <= last;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    // Registers are only written with the block idle: no result outstanding,
    // and the readout given time to fall back into its load state. The task first
    // waits on the clock so that the checker has seen the last accepted beat.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(int unsigned w, int unsigned h, int unsigned r);
        write_reg(CFG_VIEW_WIDTH, w);
        write_reg(CFG_VIEW_HEIGHT, h);
        write_reg(CFG_FILL_RATIO, r);
    endtask

    // Coordinate of a chosen spread: tiny, moderate, or anywhere in 32 bits.
    function automatic logic signed [31:0] pick_coord(int spread);
        case (spread)
            0:       return $signed($urandom_range(0, 16'hFFFF)) - 32'sd32768;
            1:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sd8388608;
            default: return $signed($urandom());
        endcase
    endfunction

    // One model of n vertices. Flat models repeat x (and for degenerate ones y).
    task automatic send_model(int n, int spread, int flat);
        logic signed [31:0] x0, y0;
        x0 = pick_coord(spread);
        y0 = pick_coord(spread);
        for (int i = 0; i < n; i++)
            send_vertex((flat >= 1) ? x0 : pick_coord(spread),
                        (flat >= 2) ? y0 : pick_coord(spread),
                        pick_coord(spread), i == n - 1);
    endtask

    initial begin
        int sent;
        int n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: the full coordinate range, under the reset settings.
        send_vertex(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1);
        // A single vertex: zero extent on both axes.
        send_vertex(32'sh1234_5678, -32'sh0000_1000, 32'sh7FFF_FFFF, 1'b1);
        // Zero x extent but some y extent; a small box under a big viewport saturates.
        send_vertex(32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_vertex(32'sh0001_0000, 32'sh0000_0001, -32'sh0000_0005, 1'b1);
        set_view(4096, 4096, 131072);
        send_vertex(32'sh0000_0000, 32'sh0000_0000, 32'sh8000_0000, 1'b0);
        send_vertex(32'sh0000_0002, -32'sh0000_0001, 32'sh7FFF_FFFF, 1'b0);
        send_vertex(-32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0000, 1'b1);
        // Zero ratio and then zero width: everything collapses to the centre.
        set_view(4096, 1, 0);
        send_model(3, 1, 0);
        write_reg(CFG_VIEW_WIDTH, 0);
        write_reg(CFG_FILL_RATIO, 52429);
        send_model(3, 2, 0);
        // Smallest viewport, ratio one.
        set_view(1, 1, 65536);
        send_model(4, 0, 0);

        // Random part: mostly small models, a full one, and one beyond capacity.
        sent = 0;
        for (int k = 0; sent < 160; k++) begin
            if (k % 4 == 0)
                set_view($urandom_range(1, 4096), $urandom_range(1, 4096),
                         $urandom_range(0, 131072));
            if (k == 3) n = 64;
            else if (k == 7) n = 67;
            else n = $urandom_range(1, 8);
            send_model(n, $urandom_range(0, 2),
                       ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
            sent += n;
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
